/* design/mte_pkg.sv */
// Package for the MIDI track event serializer: shared types, constants and the
// divide-by-25 helper used by the front end. No dependencies.
`timescale 1ns / 1ps

package mte_pkg;

    // Variable-length quantity limits
    localparam int MAX_DELTA_BYTES_DEF = 4;
    localparam int MAX_DELTA_BYTES_MAX = 4;
    localparam int TICK_W              = 7 * MAX_DELTA_BYTES_MAX;
    localparam int QUEUE_DEPTH_DEF     = 2;

    // Message kinds (status high nibble) that carry one data byte only
    localparam logic [3:0] KIND_PROG_CHANGE = 4'hC;
    localparam logic [3:0] KIND_CHAN_PRESS  = 4'hD;

    // Remainder accumulator wraps at the tick divisor
    localparam logic [6:0] TICK_DIV = 7'd50;

    // ceil(2^28 / 25): exact quotient for numerators below 2^28 / 19
    localparam logic [46:0] RECIP25 = 47'd10737419;

    typedef struct packed {
        logic [17:0] q;
        logic [4:0]  r;
    } t_div;

    typedef struct packed {
        logic [7:0] status_byte;
        logic [6:0] data_one;
        logic [6:0] data_two;
    } t_msg;

    // One classified event handed from the front end to the byte sequencer
    typedef struct packed {
        logic [TICK_W-1:0] ticks;
        logic [2:0]        ngroups;
        logic              two_bytes;
        t_msg              msg;
    } t_evt;

    // n / 25 and n % 25 for n < 25 * 2^18
    function automatic t_div div25(input logic [22:0] n);
        logic [46:0] prod;
        logic [17:0] q;
        logic [22:0] rem;
        t_div        d;
        prod = 47'(n) * RECIP25;
        q    = prod[45:28];
        rem  = n - 23'(q) * 23'd25;
        d.q  = q;
        d.r  = rem[4:0];
        return d;
    endfunction

endpackage

/* design/mte_if.sv */
// Valid/ready channel interfaces for the MIDI track event serializer.
// Input events in, track bytes out. No dependencies.
`timescale 1ns / 1ps

interface mte_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] time_ms;
    logic [7:0]  status_byte;
    logic [6:0]  data_one;
    logic [6:0]  data_two;
    logic        first_of_take;

    modport source (output valid, time_ms, status_byte, data_one, data_two, first_of_take,
                    input ready);
    modport sink   (input valid, time_ms, status_byte, data_one, data_two, first_of_take,
                    output ready);
endinterface

interface mte_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_byte;

    modport source (output valid, out_byte, last_byte, input ready);
    modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

/* design/mte_front.sv */
// Front end: takes events, forms the ms delta, scales it to ticks with a
// two-stage divide by 25, folds in the remainder accumulator. Uses mte_pkg, mte_if.
`timescale 1ns / 1ps

module mte_front #(
    parameter int MAX_DELTA_BYTES = mte_pkg::MAX_DELTA_BYTES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mte_in_if.sink       i_evt,
    output logic         o_push,
    output mte_pkg::t_evt o_evt,
    input  logic         i_full
);
    import mte_pkg::*;

    localparam logic [31:0] TICK_LIMIT = 32'((64'd1 << (7 * MAX_DELTA_BYTES)) - 64'd1);

    logic        r_v1, r_v2, r_v3;
    logic        r_f1, r_f2, r_f3;
    t_msg        r_m1, r_m2, r_m3;
    logic [35:0] r_x1;
    logic [12:0] r_qhi2;
    logic [4:0]  r_rhi2;
    logic [17:0] r_xlo2;
    logic [31:0] r_q3;
    logic [4:0]  r_rlo3;
    logic [31:0] r_prev;
    logic [5:0]  r_err;
    logic [5:0]  n_err;

    logic        advance, accept;
    logic [31:0] delta;
    t_div        d_hi, d_lo;
    logic [5:0]  err_base;
    logic [6:0]  err_sum;
    logic        carry;
    logic [31:0] ticks, ticks_sat;
    logic [2:0]  ngroups;
    logic [3:0]  kind;

    // Whole pipeline holds while the last stage cannot push
    assign advance     = !r_v3 || !i_full;
    assign i_evt.ready = advance;
    assign accept      = i_evt.valid && advance;
    assign delta       = i_evt.first_of_take ? 32'd0 : (i_evt.time_ms - r_prev);

    assign d_hi = div25({5'd0, r_x1[35:18]});
    assign d_lo = div25({r_rhi2, r_xlo2});

    // Remainder of 12*delta mod 50 is twice that of 6*delta mod 25
    always_comb begin
        err_base  = r_f3 ? 6'd0 : r_err;
        err_sum   = {1'b0, err_base} + {1'b0, r_rlo3, 1'b0};
        carry     = err_sum >= TICK_DIV;
        n_err     = carry ? 6'(err_sum - TICK_DIV) : err_sum[5:0];
        ticks     = r_q3 + {31'd0, carry};
        ticks_sat = (ticks > TICK_LIMIT) ? TICK_LIMIT : ticks;
        ngroups   = 3'd1;
        for (int g = 1; g < MAX_DELTA_BYTES; g++) begin
            if ((ticks_sat >> (7 * g)) != 32'd0) begin
                ngroups = 3'(g + 1);
            end
        end
        kind = r_m3.status_byte[7:4];
    end

    assign o_push          = r_v3 && !i_full;
    assign o_evt.ticks     = ticks_sat[TICK_W-1:0];
    assign o_evt.ngroups   = ngroups;
    assign o_evt.two_bytes = kind inside {KIND_PROG_CHANGE, KIND_CHAN_PRESS};
    assign o_evt.msg       = r_m3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_prev <= 32'd0;
            r_err  <= 6'd0;
        end else begin
            if (accept) begin
                r_prev <= i_evt.time_ms;
            end
            if (o_push) begin
                r_err <= n_err;
            end
            if (advance) begin
                r_v1 <= accept;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_x1   <= {2'b00, delta, 2'b00} + {3'b000, delta, 1'b0};
            r_f1   <= i_evt.first_of_take;
            r_m1   <= '{i_evt.status_byte, i_evt.data_one, i_evt.data_two};
            r_qhi2 <= d_hi.q[12:0];
            r_rhi2 <= d_hi.r;
            r_xlo2 <= r_x1[17:0];
            r_f2   <= r_f1;
            r_m2   <= r_m1;
            r_q3   <= {1'b0, r_qhi2, d_lo.q};
            r_rlo3 <= d_lo.r;
            r_f3   <= r_f2;
            r_m3   <= r_m2;
        end
    end

endmodule

/* design/mte_fifo.sv */
// Short event queue between the front end and the byte sequencer.
// Uses mte_pkg for the event record.
`timescale 1ns / 1ps

module mte_fifo #(
    parameter int DEPTH = mte_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mte_pkg::t_evt i_data,
    output logic          o_full,
    input  logic          i_pop,
    output mte_pkg::t_evt o_data,
    output logic          o_empty
);
    import mte_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_evt             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = r_cnt == CNT_W'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= bump(r_wr);
            end
            if (i_pop) begin
                r_rd <= bump(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

/* design/mte_back.sv */
// Byte sequencer: emits the delta-time VLQ bytes, then the message bytes,
// one beat per cycle while o_byte.ready is high. Uses mte_pkg, mte_if.
`timescale 1ns / 1ps

module mte_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mte_pkg::t_evt i_evt,
    input  logic          i_empty,
    output logic          o_pop,
    mte_out_if.source     o_byte
);
    import mte_pkg::*;

    typedef enum logic [1:0] {PH_IDLE, PH_DELTA, PH_MSG} t_phase;

    localparam logic [1:0] MI_STATUS = 2'd0;
    localparam logic [1:0] MI_DATA1  = 2'd1;
    localparam logic [1:0] MI_DATA2  = 2'd2;

    t_phase            r_phase;
    logic [2:0]        r_left;
    logic [1:0]        r_mi;
    t_evt              r_cur;

    logic [1:0]        grp_idx;
    logic [TICK_W-1:0] grp_shift;
    logic [7:0]        msg_byte;
    logic              last, beat;

    always_comb begin
        grp_idx   = 2'(r_left - 3'd1);
        grp_shift = r_cur.ticks >> (5'd7 * {3'd0, grp_idx});
        case (r_mi)
            MI_STATUS: msg_byte = r_cur.msg.status_byte;
            MI_DATA1:  msg_byte = {1'b0, r_cur.msg.data_one};
            default:   msg_byte = {1'b0, r_cur.msg.data_two};
        endcase
        last = (r_phase == PH_MSG) &&
               ((r_mi == MI_DATA1 && r_cur.two_bytes) || r_mi == MI_DATA2);
    end

    assign o_byte.valid     = r_phase != PH_IDLE;
    assign o_byte.out_byte  = (r_phase == PH_DELTA) ? {r_left > 3'd1, grp_shift[6:0]}
                                                    : msg_byte;
    assign o_byte.last_byte = last;
    assign beat             = o_byte.valid && o_byte.ready;
    // Next event loads on the same edge as the final beat of this one
    assign o_pop            = ((r_phase == PH_IDLE) || (beat && last)) && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_left  <= 3'd0;
            r_mi    <= MI_STATUS;
        end else if (o_pop) begin
            r_cur   <= i_evt;
            r_phase <= PH_DELTA;
            r_left  <= i_evt.ngroups;
            r_mi    <= MI_STATUS;
        end else if (beat && last) begin
            r_phase <= PH_IDLE;
        end else if (beat) begin
            case (r_phase)
                PH_DELTA: begin
                    if (r_left == 3'd1) begin
                        r_phase <= PH_MSG;
                        r_mi    <= MI_STATUS;
                    end else begin
                        r_left <= r_left - 3'd1;
                    end
                end
                PH_MSG: begin
                    r_mi <= r_mi + 2'd1;
                end
                default: begin
                    r_phase <= PH_IDLE;
                end
            endcase
        end
    end

endmodule

/* design/midi_track_event_serializer_unit.sv */
// An event's first byte is offered after the front pipeline, the event queue and
// the sequencer's event register. One output beat per cycle while ready is high;
// an event takes ngroups + 2 or 3 beats (3 to 7), set by the byte sequencer; the
// front end takes one event per cycle unless a full queue holds it. Reset clears
// (sync, active low) the previous time, tick remainder, front pipeline and queue.
`timescale 1ns / 1ps

module midi_track_event_serializer_unit #(
    parameter int MAX_DELTA_BYTES = mte_pkg::MAX_DELTA_BYTES_DEF,
    parameter int QUEUE_DEPTH     = mte_pkg::QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mte_in_if.sink    i_evt,
    mte_out_if.source o_byte
);
    import mte_pkg::*;

    logic push, full, pop, empty;
    t_evt front_evt, queue_evt;

    mte_front #(
        .MAX_DELTA_BYTES(MAX_DELTA_BYTES)
    ) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_evt  (i_evt),
        .o_push (push),
        .o_evt  (front_evt),
        .i_full (full)
    );

    mte_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (front_evt),
        .o_full (full),
        .i_pop  (pop),
        .o_data (queue_evt),
        .o_empty(empty)
    );

    mte_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_evt  (queue_evt),
        .i_empty(empty),
        .o_pop  (pop),
        .o_byte (o_byte)
    );

endmodule

/* sim/midi_track_event_serializer_unit_test.sv */
// Self-checking testbench for midi_track_event_serializer_unit: drives directed and random
// MIDI events and checks every emitted track byte against a local model of the tick and VLQ
// encoding. Depends on mte_pkg, mte_if.sv and the serializer RTL.
`timescale 1ns / 1ps

module midi_track_event_serializer_unit_test;
    import mte_pkg::*;

    localparam int          TICK_MUL     = 12;
    localparam logic [63:0] VLQ_LIMIT    = (64'd1 << (7 * MAX_DELTA_BYTES_DEF)) - 64'd1;
    localparam int          DRAIN_CYCLES = 20;
    localparam int          TIMEOUT_NS   = 4_000_000;
    localparam int          PRINT_CAP    = 50;

    typedef struct packed {
        logic [31:0] time_ms;
        t_msg        msg;
        logic        first;
    } t_midi_event;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } t_track_byte;

    logic clk;
    logic rst_n;

    mte_in_if  evt_if ();
    mte_out_if byte_if ();

    midi_track_event_serializer_unit u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_evt   (evt_if),
        .o_byte  (byte_if)
    );

    // model state
    logic [31:0] prev_stamp_ms;
    logic [5:0]  tick_rem;

    t_track_byte track_bytes_due[$];
    logic [31:0] clock_ms;
    int          mismatches;
    int          tx_gap_max;
    int          rx_gap_max;
    int          rx_hold_cycles;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_CAP) begin
            $display("%0t: mismatch: %s", $time, what);
        end
    endtask

    // Delta to ticks with carried remainder, then VLQ delta bytes and message bytes
    function automatic void predict_track_bytes(input t_midi_event ev);
        logic [31:0] delta_ms;
        logic [63:0] scaled;
        logic [63:0] ticks;
        logic [6:0]  rem_sum;
        logic [6:0]  groups [MAX_DELTA_BYTES_DEF];
        int          ngroups;
        logic        two_bytes;
        t_track_byte tb;
        if (ev.first) begin
            tick_rem = '0;
            delta_ms = '0;
        end else begin
            delta_ms = ev.time_ms - prev_stamp_ms;
        end
        prev_stamp_ms = ev.time_ms;

        scaled  = 64'(delta_ms) * TICK_MUL;
        ticks   = scaled / TICK_DIV;
        rem_sum = 7'(tick_rem) + 7'(scaled % TICK_DIV);
        if (rem_sum >= TICK_DIV) begin
            rem_sum = rem_sum - TICK_DIV;
            ticks   = ticks + 64'd1;
        end
        tick_rem = rem_sum[5:0];
        if (ticks > VLQ_LIMIT) begin
            ticks = VLQ_LIMIT;
        end

        ngroups = 0;
        do begin
            groups[ngroups] = ticks[6:0];
            ngroups++;
            ticks = ticks >> 7;
        end while (ticks != 0 && ngroups < MAX_DELTA_BYTES_DEF);

        for (int i = ngroups - 1; i >= 0; i--) begin
            tb.value = {(i > 0), groups[i]};
            tb.last  = 1'b0;
            track_bytes_due.push_back(tb);
        end

        two_bytes = (ev.msg.status_byte[7:4] == KIND_PROG_CHANGE) ||
                    (ev.msg.status_byte[7:4] == KIND_CHAN_PRESS);
        tb.value = ev.msg.status_byte;
        tb.last  = 1'b0;
        track_bytes_due.push_back(tb);
        tb.value = {1'b0, ev.msg.data_one};
        tb.last  = two_bytes;
        track_bytes_due.push_back(tb);
        if (!two_bytes) begin
            tb.value = {1'b0, ev.msg.data_two};
            tb.last  = 1'b1;
            track_bytes_due.push_back(tb);
        end
    endfunction

    // Offer one event delta_ms after the previous one; valid stays high on return
    task automatic send_event(input logic [31:0] delta_ms, input logic [7:0] status,
                              input logic [6:0] d1, input logic [6:0] d2,
                              input logic first);
        int          gap;
        t_midi_event ev;
        clock_ms              = clock_ms + delta_ms;
        ev.time_ms            = clock_ms;
        ev.msg.status_byte    = status;
        ev.msg.data_one       = d1;
        ev.msg.data_two       = d2;
        ev.first              = first;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            evt_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        evt_if.valid         <= 1'b1;
        evt_if.time_ms       <= ev.time_ms;
        evt_if.status_byte   <= status;
        evt_if.data_one      <= d1;
        evt_if.data_two      <= d2;
        evt_if.first_of_take <= first;
        do @(posedge clk); while (!evt_if.ready);
        predict_track_bytes(ev);
    endtask

    // Call straight after the last beat of a phase
    task automatic wait_track_drained();
        evt_if.valid <= 1'b0;
        while (track_bytes_due.size() != 0) @(posedge clk);
    endtask

    // Output side: random stall per beat, optional long hold, checks each beat
    initial begin : byte_sink
        int          stall;
        t_track_byte want;
        byte_if.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (rx_hold_cycles > 0) begin
                stall          = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                stall = $urandom_range(0, rx_gap_max);
            end
            if (stall > 0) begin
                byte_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            byte_if.ready <= 1'b1;
            do @(posedge clk); while (!byte_if.valid);
            if (track_bytes_due.size() == 0) begin
                report_mismatch($sformatf("unexpected byte 0x%02h last %b",
                                          byte_if.out_byte, byte_if.last_byte));
            end else begin
                want = track_bytes_due.pop_front();
                if (byte_if.out_byte !== want.value) begin
                    report_mismatch($sformatf("out_byte 0x%02h, want 0x%02h",
                                              byte_if.out_byte, want.value));
                end
                if (byte_if.last_byte !== want.last) begin
                    report_mismatch($sformatf("last_byte %b, want %b (byte 0x%02h)",
                                              byte_if.last_byte, want.last, want.value));
                end
            end
        end
    end

    // One to four delta bytes, saturation, and an unmarked first event after reset
    task automatic test_vlq_lengths();
        tx_gap_max = 3;
        rx_gap_max = 3;
        send_event(32'd1000, 8'h90, 7'd0, 7'd127, 1'b0);
        clock_ms = 32'd5000;
        send_event(32'd0, 8'h80, 7'd127, 7'd0, 1'b1);
        send_event(32'd534, 8'h90, 7'h55, 7'h2A, 1'b0);
        send_event(32'd100_000, 8'hA3, 7'h2A, 7'h55, 1'b0);
        send_event(32'd10_000_000, 8'hB7, 7'd1, 7'd64, 1'b0);
        send_event(32'hFFFF_FFFF, 8'hE0, 7'd64, 7'd1, 1'b0);
        // lands exactly on the 28-bit limit
        send_event(32'd1_118_481_066, 8'h9F, 7'd127, 7'd127, 1'b0);
        wait_track_drained();
    endtask

    // Every message kind, channel extremes, and status bytes below 0x80
    task automatic test_message_kinds();
        logic [7:0] status;
        for (int kind = 8; kind < 16; kind++) begin
            status = {4'(kind), (kind % 2 == 0) ? 4'h0 : 4'hF};
            send_event($urandom_range(0, 600), status, (kind % 2 == 0) ? 7'd0 : 7'd127,
                       (kind % 2 == 0) ? 7'd127 : 7'd0, 1'b0);
        end
        send_event(32'd20, 8'h00, 7'd5, 7'd6, 1'b0);
        send_event(32'd20, 8'h7F, 7'd7, 7'd8, 1'b0);
        wait_track_drained();
    endtask

    // Remainder carry, clearing on a new take, and timer wrap
    task automatic test_remainder_and_wrap();
        repeat (2) send_event(32'd1, 8'h90, 7'd60, 7'd100, 1'b0);
        send_event(32'd77, 8'h80, 7'd60, 7'd0, 1'b1);
        // fifth 1 ms step brings the remainder sum to 60, which wraps to 10 and adds a tick
        repeat (5) send_event(32'd1, 8'h90, 7'd61, 7'd90, 1'b0);
        clock_ms = 32'hFFFF_FF00;
        send_event(32'd0, 8'hC5, 7'd12, 7'd0, 1'b1);
        send_event(32'h0000_0200, 8'hD5, 7'd99, 7'd33, 1'b0);
        wait_track_drained();
    endtask

    task automatic send_random_event();
        logic [31:0] delta_ms;
        logic [7:0]  status;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: delta_ms = $urandom_range(0, 600);
            5, 6:          delta_ms = $urandom_range(0, 70_000);
            7:             delta_ms = $urandom_range(0, 2_000_000);
            default:       delta_ms = $urandom;
        endcase
        status = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 127))
                                              : 8'($urandom_range(128, 255));
        send_event(delta_ms, status, 7'($urandom), 7'($urandom),
                   $urandom_range(0, 19) == 0);
    endtask

    // Random events under four idling mixes, including none at all
    task automatic test_random_traffic();
        int tx_modes [4] = '{12, 0, 0, 12};
        int rx_modes [4] = '{12, 0, 12, 0};
        for (int m = 0; m < 4; m++) begin
            tx_gap_max = tx_modes[m];
            rx_gap_max = rx_modes[m];
            repeat (70) send_random_event();
            wait_track_drained();
        end
    endtask

    // Output held off for a long stretch while events keep coming in back to back
    task automatic test_input_stall();
        tx_gap_max     = 0;
        rx_gap_max     = 2;
        rx_hold_cycles = 300;
        repeat (12) send_random_event();
        wait_track_drained();
    endtask

    initial begin
        mismatches           = 0;
        rx_hold_cycles       = 0;
        tx_gap_max           = 0;
        rx_gap_max           = 0;
        clock_ms             = '0;
        prev_stamp_ms        = '0;
        tick_rem             = '0;
        rst_n               <= 1'b0;
        evt_if.valid        <= 1'b0;
        evt_if.time_ms      <= '0;
        evt_if.status_byte  <= '0;
        evt_if.data_one     <= '0;
        evt_if.data_two     <= '0;
        evt_if.first_of_take <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_vlq_lengths();
        test_message_kinds();
        test_remainder_and_wrap();
        test_random_traffic();
        test_input_stall();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
